@@ rtl/ece_pkg.sv @@
// ----------------------------------------------------------------------------
// ece_pkg: shared types and constants for the C escape collapse unit
// Transaction payloads, the per-transaction push bundle and character codes.
// ----------------------------------------------------------------------------
package ece_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } ece_in_t;

  // Result transaction payload
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [15:0] out_length;
    logic        run_last;
  } ece_out_t;

  // Results produced by one input transaction, handed to the result queue
  typedef struct packed {
    logic [1:0]         count;
    ece_out_t [2:0]     item;
  } ece_push_t;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Reset value of the bell register (ASCII BEL)
  localparam logic [7:0] BELL_RESET = 8'h07;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_X         = 8'h78;

  // Control codes produced by the simple escapes
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;
  localparam logic [7:0] CODE_VTAB = 8'h0B;

  // Digit limits for pending numbers
  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

endpackage

@@ rtl/ece_decode.sv @@
// ----------------------------------------------------------------------------
// ece_decode: escape decoder with parse state
// Holds the escape state and length counter, and forms the up to three
// results that one input transaction causes.
// ----------------------------------------------------------------------------
module ece_decode #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  ece_pkg::ece_in_t  in_item,
  input  logic [7:0]        bell_code,
  output ece_pkg::ece_push_t push
);
  import ece_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_OCT
  } mode_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = {COUNT_WIDTH{1'b1}};

  mode_t                  mode;
  logic [1:0]             digit_count;
  logic [7:0]             number_accum;
  logic [COUNT_WIDTH-1:0] produced_count;

  mode_t                  mode_next;
  logic [1:0]             digit_count_next;
  logic [7:0]             number_accum_next;
  logic [COUNT_WIDTH-1:0] produced_count_next;

  logic [7:0]             c;
  logic                   last;
  logic                   is_hex_mode;
  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic                   oct_ok;
  logic                   digit_ok;
  logic [1:0]             dc_inc;
  logic                   plain;
  logic [1:0]             nd;
  logic [7:0]             dat [2];
  logic [1:0]             total;
  logic [COUNT_WIDTH+1:0] count_sum;
  logic [COUNT_WIDTH-1:0] count_sat;
  logic [31:0]            len_wide;
  logic [15:0]            len_out;

  assign c    = in_item.in_byte;
  assign last = in_item.is_last;

  // Digit classification
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_ok  = 1'b1;
      hex_val = c[3:0] + 4'd9;
    end
  end

  assign oct_ok      = (c >= 8'h30) && (c <= 8'h37);
  assign is_hex_mode = (mode == MODE_HEX);
  assign digit_ok    = is_hex_mode ? hex_ok : oct_ok;
  assign dc_inc      = digit_count + 2'd1;

  // Escape parsing: next state and data bytes in emit order
  always_comb begin
    mode_next         = mode;
    digit_count_next  = digit_count;
    number_accum_next = number_accum;
    nd                = 2'd0;
    dat[0]            = 8'h00;
    dat[1]            = 8'h00;
    plain             = 1'b0;

    case (mode)
      MODE_PLAIN: begin
        plain = 1'b1;
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        case (c)
          CH_NEWLINE: ;
          CH_A: begin dat[0] = bell_code; nd = 2'd1; end
          CH_B: begin dat[0] = CODE_BS;   nd = 2'd1; end
          CH_F: begin dat[0] = CODE_FF;   nd = 2'd1; end
          CH_N: begin dat[0] = CODE_LF;   nd = 2'd1; end
          CH_R: begin dat[0] = CODE_CR;   nd = 2'd1; end
          CH_T: begin dat[0] = CODE_TAB;  nd = 2'd1; end
          CH_V: begin dat[0] = CODE_VTAB; nd = 2'd1; end
          CH_X: begin
            mode_next         = MODE_HEX;
            digit_count_next  = 2'd0;
            number_accum_next = 8'h00;
          end
          default: begin
            if (oct_ok) begin
              mode_next         = MODE_OCT;
              digit_count_next  = 2'd1;
              number_accum_next = {5'b0, c[2:0]};
            end else begin
              dat[0] = c;
              nd     = 2'd1;
            end
          end
        endcase
      end
      default: begin
        // Hex or octal number pending
        if (digit_ok) begin
          number_accum_next = is_hex_mode ? {number_accum[3:0], hex_val}
                                          : {number_accum[4:0], c[2:0]};
          digit_count_next  = dc_inc;
          if (dc_inc == (is_hex_mode ? HEX_DIGITS : OCT_DIGITS)) begin
            mode_next        = MODE_PLAIN;
            digit_count_next = 2'd0;
            dat[0]           = number_accum_next;
            nd               = 2'd1;
          end
        end else begin
          // Non-digit flushes the number, then counts as plain text
          mode_next        = MODE_PLAIN;
          digit_count_next = 2'd0;
          dat[0]           = number_accum;
          nd               = 2'd1;
          plain            = 1'b1;
        end
      end
    endcase

    if (plain) begin
      if (c == CH_BACKSLASH) begin
        mode_next = MODE_ESC;
      end else begin
        dat[nd[0]] = c;
        nd         = nd + 2'd1;
      end
    end

    // End of string: flush a pending number, drop a lone backslash
    if (last) begin
      if (mode_next == MODE_HEX || mode_next == MODE_OCT) begin
        dat[nd[0]] = number_accum_next;
        nd         = nd + 2'd1;
      end
      mode_next         = MODE_PLAIN;
      digit_count_next  = 2'd0;
      number_accum_next = 8'h00;
    end
  end

  // Saturating length count
  assign count_sum = {2'b00, produced_count} + {{COUNT_WIDTH{1'b0}}, nd};
  assign count_sat = (count_sum > {2'b00, COUNT_CAP}) ? COUNT_CAP
                                                      : count_sum[COUNT_WIDTH-1:0];
  assign len_wide  = 32'(count_sat);
  assign len_out   = (len_wide > 32'h0000_FFFF) ? 16'hFFFF : len_wide[15:0];
  assign produced_count_next = last ? '0 : count_sat;
  assign total = nd + {1'b0, last};

  // Result slots: data bytes first, then the end summary
  always_comb begin
    push.count = take ? total : 2'd0;
    for (int i = 0; i < 3; i++) begin
      push.item[i].kind       = KIND_DATA;
      push.item[i].out_byte   = 8'h00;
      push.item[i].out_length = 16'h0000;
      if (2'(i) < nd) begin
        push.item[i].out_byte = dat[i[0]];
      end else begin
        push.item[i].kind       = KIND_END;
        push.item[i].out_length = len_out;
      end
      push.item[i].run_last = (2'(i) == total - 2'd1);
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_PLAIN;
      digit_count    <= 2'd0;
      number_accum   <= 8'h00;
      produced_count <= '0;
    end else if (take) begin
      mode           <= mode_next;
      digit_count    <= digit_count_next;
      number_accum   <= number_accum_next;
      produced_count <= produced_count_next;
    end
  end

endmodule

@@ rtl/ece_result_queue.sv @@
// ----------------------------------------------------------------------------
// ece_result_queue: four-entry result queue
// Takes up to three results per cycle and delivers one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ece_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  ece_pkg::ece_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output ece_pkg::ece_out_t  out_data
);
  import ece_pkg::*;

  ece_out_t   entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  // Room for a full three-result transaction
  assign room      = (count <= 3'd1);
  assign out_data  = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) begin
        entries[wr_ptr + 2'(i)] <= push.item[i];
      end
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

@@ rtl/c_escape_collapse_unit.sv @@
// ----------------------------------------------------------------------------
// c_escape_collapse_unit: streaming C escape sequence collapser
// Results are written into the result queue and offered from its head.
// Throughput: 1 input per cycle while in_ready is high; the four-entry result
// queue holds in_ready low while more than one result waits, so with the result
// side ready an input with two or three results holds off the next input.
// Reset: rst clears parse state, length count and queue; bell_code goes to 7.
// ----------------------------------------------------------------------------
module c_escape_collapse_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ece_pkg::ece_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ece_pkg::ece_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import ece_pkg::*;

  logic [7:0] bell_reg;
  logic       take;
  ece_push_t  push;

  // Bell code register
  always_ff @(posedge clk) begin
    if (rst) begin
      bell_reg <= BELL_RESET;
    end else if (cfg_we) begin
      bell_reg <= cfg_wdata;
    end
  end

  assign take = in_valid && in_ready;

  ece_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_item  (in_data),
    .bell_code(bell_reg),
    .push     (push)
  );

  ece_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ rtl/ece_checker.sv @@
// ----------------------------------------------------------------------------
// ece_port_checks: port-level checks for the escape collapse unit
// Watches the result channel, input stalls and reset behavior.
// ----------------------------------------------------------------------------
module ece_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ece_pkg::ece_out_t out_data
);
  import ece_pkg::*;

  // A stalled result stays offered with the same payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

  // End summary carries a zero byte and closes its transaction's results
  a_end_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_END |->
      out_data.out_byte == 8'h00 && out_data.run_last)
    else $error("malformed end summary");

  // Data results carry no length
  a_data_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DATA |-> out_data.out_length == 16'h0000)
    else $error("data result with length");

  // Input is held off only while results are waiting
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind c_escape_collapse_unit ece_port_checks u_ece_port_checks (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ test/ece_checker.sv @@
// ----------------------------------------------------------------------------
// ece_checker: result predictor and comparator for the escape collapse unit
// Watches the input, result and bell register ports, predicts the collapsed
// byte stream and end-of-string summaries, and compares every result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module ece_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  ece_pkg::ece_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ece_pkg::ece_out_t out_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  import ece_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_OCTAL
  } parse_mode_t;

  localparam logic [15:0] LENGTH_CAP   = 16'hFFFF;
  localparam int          REPORT_LIMIT = 10;
  localparam logic [4:0]  NO_DIGIT     = 5'h10;
  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  CH_SEVEN     = 8'h37;
  localparam logic [7:0]  CH_NINE      = 8'h39;
  localparam logic [7:0]  CH_UPPER_A   = 8'h41;
  localparam logic [7:0]  CH_UPPER_F   = 8'h46;
  localparam logic [7:0]  CH_LOWER_F   = 8'h66;

  // Predicted parser state
  parse_mode_t mode;
  logic [1:0]  digits;
  logic [7:0]  accum;
  logic [15:0] produced;
  logic [7:0]  bell;

  ece_out_t expected_results[$];
  int       mismatches;
  int       matched;

  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, c[3:0]};
    // 'a'..'f' and 'A'..'F' share the low nibble 1..6
    if ((c >= CH_A && c <= CH_LOWER_F) || (c >= CH_UPPER_A && c <= CH_UPPER_F))
      return {1'b0, c[3:0] + 4'd9};
    return NO_DIGIT;
  endfunction

  function automatic logic [4:0] octal_digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_SEVEN) return {2'b00, c[2:0]};
    return NO_DIGIT;
  endfunction

  // Data byte out; the length count sticks at its cap
  task automatic emit_data_byte(input logic [7:0] b);
    if (produced != LENGTH_CAP) produced = produced + 16'd1;
    expected_results.push_back('{kind: KIND_DATA, out_byte: b, out_length: 16'd0,
                                 run_last: 1'b0});
  endtask

  task automatic text_byte(input logic [7:0] c);
    if (c == CH_BACKSLASH) mode = MODE_ESCAPE;
    else emit_data_byte(c);
  endtask

  // Byte following a backslash
  task automatic escape_byte(input logic [7:0] c);
    mode = MODE_TEXT;
    case (c)
      CH_NEWLINE: ;
      CH_A: emit_data_byte(bell);
      CH_B: emit_data_byte(CODE_BS);
      CH_F: emit_data_byte(CODE_FF);
      CH_N: emit_data_byte(CODE_LF);
      CH_R: emit_data_byte(CODE_CR);
      CH_T: emit_data_byte(CODE_TAB);
      CH_V: emit_data_byte(CODE_VTAB);
      CH_X: begin
        mode   = MODE_HEX;
        digits = 2'd0;
        accum  = 8'd0;
      end
      default: begin
        if (octal_digit_value(c) != NO_DIGIT) begin
          mode   = MODE_OCTAL;
          digits = 2'd1;
          accum  = {5'd0, c[2:0]};
        end else begin
          emit_data_byte(c);
        end
      end
    endcase
  endtask

  // Byte while a hex or octal number is pending
  task automatic number_byte(input logic [7:0] c);
    logic [4:0] v;
    logic       is_hex;
    is_hex = (mode == MODE_HEX);
    v = is_hex ? hex_digit_value(c) : octal_digit_value(c);
    if (v != NO_DIGIT) begin
      accum  = is_hex ? {accum[3:0], v[3:0]} : {accum[4:0], v[2:0]};
      digits = digits + 2'd1;
      if (digits >= (is_hex ? HEX_DIGITS : OCT_DIGITS)) begin
        mode   = MODE_TEXT;
        digits = 2'd0;
        emit_data_byte(accum);
      end
    end else begin
      // non-digit closes the number, then is handled as plain text
      mode   = MODE_TEXT;
      digits = 2'd0;
      emit_data_byte(accum);
      text_byte(c);
    end
  endtask

  // One input transaction: queue every result it causes
  task automatic parse_byte(input logic [7:0] c, input logic last);
    int       queued_prior;
    ece_out_t tail;
    queued_prior = expected_results.size();
    case (mode)
      MODE_TEXT:   text_byte(c);
      MODE_ESCAPE: escape_byte(c);
      default:     number_byte(c);
    endcase
    if (last) begin
      // flush a pending number; a lone backslash is simply dropped
      if (mode == MODE_HEX || mode == MODE_OCTAL) emit_data_byte(accum);
      expected_results.push_back('{kind: KIND_END, out_byte: 8'd0, out_length: produced,
                                   run_last: 1'b0});
      mode     = MODE_TEXT;
      digits   = 2'd0;
      accum    = 8'd0;
      produced = 16'd0;
    end
    if (expected_results.size() > queued_prior) begin
      tail = expected_results.pop_back();
      tail.run_last = 1'b1;
      expected_results.push_back(tail);
    end
  endtask

  task automatic compare_result(input ece_out_t got);
    ece_out_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("ERROR: unexpected result kind=%0d byte=%02h len=%0d run_last=%0d",
                 got.kind, got.out_byte, got.out_length, got.run_last);
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.out_length !== want.out_length || got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR: result %0d expected kind=%0d byte=%02h len=%0d run_last=%0d",
                   matched + mismatches, want.kind, want.out_byte, want.out_length,
                   want.run_last);
          $display("ERROR: result %0d got      kind=%0d byte=%02h len=%0d run_last=%0d",
                   matched + mismatches, got.kind, got.out_byte, got.out_length,
                   got.run_last);
        end
      end else begin
        matched++;
      end
    end
  endtask

  // Results are compared first: a result never stems from the input taken
  // at the same edge. An input taken at a bell write edge sees the old code.
  always @(posedge clk) begin
    if (rst) begin
      mode       = MODE_TEXT;
      digits     = 2'd0;
      accum      = 8'd0;
      produced   = 16'd0;
      bell       = BELL_RESET;
      mismatches = 0;
      matched    = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) parse_byte(in_data.in_byte, in_data.is_last);
      if (cfg_we) bell = cfg_wdata;
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
    checked    <= matched;
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for c_escape_collapse_unit
// Sends directed strings back to back, then random strings with C escape
// sequences under random input gaps and result backpressure, changing the
// bell code between phases. Prediction and comparison live in ece_checker;
// this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ece_pkg::*;

  localparam int         RANDOM_ITEMS    = 280;
  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam int         SETTLE_CYCLES   = 4;
  localparam logic [7:0] BELL_EBCDIC     = 8'd47;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  ece_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  ece_out_t   out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int idle_cycles;
  int bytes_sent;
  int strings_sent;
  int random_sent;
  bit gaps_enabled;

  string      hex_chars = "0123456789abcdefABCDEF";
  string      oct_chars = "01234567";
  logic [7:0] simple_letters [7] = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V};
  logic [7:0] text_buf[$];

  c_escape_collapse_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ece_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: consecutive cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result backpressure: mostly ready, short stalls, a few long ones
  initial begin
    int r;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end else if (r < 90) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.in_byte = b;
    in_data.is_last = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
    strings_sent++;
  endtask

  // Wait until every predicted result has arrived and the block is quiet
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bell(input logic [7:0] code);
    @(negedge clk);
    cfg_wdata = code;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One token: plain byte, escape sequence, or noise
  task automatic add_token();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (r < 50) begin
      text_buf.push_back(CH_BACKSLASH);
      text_buf.push_back(simple_letters[$urandom_range(0, 6)]);
    end else if (r < 55) begin
      text_buf.push_back(CH_BACKSLASH);
      text_buf.push_back(CH_NEWLINE);
    end else if (r < 68) begin
      text_buf.push_back(CH_BACKSLASH);
      text_buf.push_back(CH_X);
      n = $urandom_range(0, 3);
      repeat (n) text_buf.push_back(hex_chars[$urandom_range(0, 21)]);
    end else if (r < 83) begin
      text_buf.push_back(CH_BACKSLASH);
      n = $urandom_range(1, 4);
      repeat (n) text_buf.push_back(oct_chars[$urandom_range(0, 7)]);
    end else if (r < 90) begin
      // escaped arbitrary byte, NUL and 8/9 included
      text_buf.push_back(CH_BACKSLASH);
      text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      text_buf.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
    end
  endtask

  task automatic build_random_text();
    int tokens;
    text_buf = {};
    tokens = $urandom_range(1, 8);
    repeat (tokens) add_token();
    if ($urandom_range(0, 9) == 0) text_buf.push_back(CH_BACKSLASH);
  endtask

  task automatic random_phase(input int quota);
    int target;
    target = random_sent + quota;
    while (random_sent < target) begin
      build_random_text();
      send_text();
      random_sent += text_buf.size();
    end
  endtask

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    gaps_enabled = 1'b0;
    idle_cycles  = 0;
    bytes_sent   = 0;
    strings_sent = 0;
    random_sent  = 0;
    rst          = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed strings, inputs back to back
    // Every simple escape, bell at its reset code
    text_buf = {};
    foreach (simple_letters[i]) begin
      text_buf.push_back(CH_BACKSLASH);
      text_buf.push_back(simple_letters[i]);
    end
    send_text();
    // Byte extremes, octal overflow at the digit limit, hex with no digits
    // closed by a non-digit
    text_buf = {8'h00, 8'hFF, CH_BACKSLASH, oct_chars[7], oct_chars[7], oct_chars[7],
                CH_BACKSLASH, CH_X, "g"};
    send_text();
    // Hex number pending at end of string
    text_buf = {CH_BACKSLASH, CH_X, hex_chars[4]};
    send_text();
    // Lone trailing backslash
    text_buf = {CH_BACKSLASH};
    send_text();
    gaps_enabled = 1'b1;

    drain();
    write_bell(8'h00);
    random_phase(RANDOM_ITEMS / 4);

    drain();
    write_bell(8'hFF);
    random_phase(RANDOM_ITEMS / 4);

    drain();
    write_bell(BELL_EBCDIC);
    random_phase(RANDOM_ITEMS / 4);

    drain();
    write_bell(8'($urandom_range(1, 254)));
    random_phase(RANDOM_ITEMS / 4);

    drain();
    $display("Summary: %0d strings, %0d input bytes (%0d in random strings), %0d matched",
             strings_sent, bytes_sent, random_sent, checked);
    $display("Summary: bell codes reset/0/255/47/random, directed strings back to back");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
